FILE: rtl/core/timed_command_history_average_top_assert.svh
// Assertion helpers, sampled on clk, disabled in rst.
`ifndef TIMED_COMMAND_HISTORY_AVERAGE_TOP_ASSERT_SVH
`define TIMED_COMMAND_HISTORY_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication
`define TCHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tcha_pkg.sv
`timescale 1ns / 1ps
package tcha_pkg;
  localparam int HISTORY_DEPTH = 64;
  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = 7;
  localparam int TIME_W = 48;
  localparam int CMDV_W = 16;
  localparam int WIN_W = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [WIN_W-1:0] MIN_WINDOW_RESET = 24'd10000;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OLDER    = 3'd1;
  localparam logic [2:0] ST_FUTURE   = 3'd2;
  localparam logic [2:0] ST_REVERSED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_BEFORE   = 3'd5;
  localparam logic [2:0] ST_SHORT    = 3'd6;
  localparam logic [2:0] ST_FULL     = 3'd7;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CMDV_W-1:0] speed_cmd;
    logic signed [CMDV_W-1:0] turn_cmd;
    logic [TIME_W-1:0]        time_a;
    logic [TIME_W-1:0]        time_b;
    logic [TIME_W-1:0]        now_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [CMDV_W-1:0] avg_speed;
    logic signed [CMDV_W-1:0] avg_turn;
    logic [CNT_W-1:0]         entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CMDV_W-1:0] speed;
    logic signed [CMDV_W-1:0] turn;
    logic [TIME_W-1:0]        time_a;
    logic [TIME_W-1:0]        time_b;
    logic [TIME_W-1:0]        window;
    logic                     reversed;
    logic                     future;
    logic                     too_short;
  } job_t;
endpackage

FILE: rtl/core/tcha_front.sv
`timescale 1ns / 1ps
module tcha_front (
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  tcha_pkg::in_beat_t     cmd_data,
  input  logic [tcha_pkg::WIN_W-1:0] min_window,
  input  logic                   q_full,
  output logic                   push,
  output tcha_pkg::job_t         job
);
  import tcha_pkg::*;

  logic [TIME_W-1:0] window;

  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full;
  assign window    = cmd_data.time_b - cmd_data.time_a;

  always_comb begin
    job.cmd       = cmd_data.cmd;
    job.speed     = cmd_data.speed_cmd;
    job.turn      = cmd_data.turn_cmd;
    job.time_a    = cmd_data.time_a;
    job.time_b    = cmd_data.time_b;
    job.window    = window;
    job.reversed  = cmd_data.time_b < cmd_data.time_a;
    job.future    = cmd_data.time_a > cmd_data.now_time;
    job.too_short = window <= {{(TIME_W-WIN_W){1'b0}}, min_window};
  end
endmodule

FILE: rtl/core/tcha_queue.sv
`timescale 1ns / 1ps
module tcha_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcha_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output tcha_pkg::job_t job_out
);
  import tcha_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  job_t            slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wptr;
  logic [QP_W-1:0] rptr;
  logic [QC_W-1:0] fill;

  assign full    = fill == QC_W'(QUEUE_DEPTH);
  assign avail   = fill != '0;
  assign job_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QP_W'(1);
      if (pop)  rptr <= (rptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QP_W'(1);
      fill <= fill + QC_W'(push) - QC_W'(pop);
    end
  end
endmodule

FILE: rtl/core/tcha_back.sv
`timescale 1ns / 1ps
`include "timed_command_history_average_top_assert.svh"
module tcha_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_avail,
  input  tcha_pkg::job_t      job,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output tcha_pkg::out_beat_t rsp_data
);
  import tcha_pkg::*;

  typedef struct packed {
    logic signed [CMDV_W-1:0] speed;
    logic signed [CMDV_W-1:0] turn;
    logic [TIME_W-1:0]        tstamp;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ISSUE, S_WALK, S_MAC, S_DIV, S_SIGN, S_DONE
  } state_t;

  state_t            state;
  ent_t              mem [HISTORY_DEPTH];
  ent_t              rd_data;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;

  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  oldest;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  kreg;
  job_t              cj;
  logic [TIME_W-1:0] start;
  logic [TIME_W-1:0] weight;
  logic signed [CMDV_W-1:0] cur_s, cur_t, nxt_s, nxt_t;
  logic              final_seg;
  logic [2:0]        mstep;
  logic signed [40:0] prod;
  logic signed [40:0] prod_next;
  logic signed [CMDV_W-1:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [63:0] prod_ext;
  logic signed [63:0] acc_s, acc_t;
  logic [63:0]       dv_s, dv_t;
  logic [TIME_W-1:0] rm_s, rm_t;
  logic [TIME_W:0]   tr_s, tr_t;
  logic              neg_s, neg_t;
  logic [5:0]        dcnt;
  logic [2:0]        res_status;
  logic signed [CMDV_W-1:0] res_s, res_t;
  logic [CNT_W-1:0]  del_k;
  logic [CNT_W-1:0]  del_drop;
  logic              last_entry;

  assign pop = (state == S_IDLE) && job_avail;
  assign rd_en = pop || (state == S_ISSUE);
  assign wr_addr = oldest + count[PTR_W-1:0];
  assign wr_en = (state == S_CHECK) && (cj.cmd == CMD_APPEND)
              && !(count != '0 && rd_data.tstamp > cj.time_a)
              && !cj.future && (count != CNT_W'(HISTORY_DEPTH));
  assign last_entry = (j + CNT_W'(1)) == count;
  assign del_k    = (cj.time_a > rd_data.tstamp) ? j : kreg;
  assign del_drop = del_k - CNT_W'(1);

  always_comb begin
    if (state == S_ISSUE) rd_addr = oldest + j[PTR_W-1:0];
    else if (job.cmd == CMD_APPEND) rd_addr = oldest + count[PTR_W-1:0] - PTR_W'(1);
    else rd_addr = oldest;
  end

  // four 16x24 partial products: speed lo/hi, turn lo/hi
  assign mul_a = (mstep < 3'd2) ? cur_s : cur_t;
  assign mul_b = mstep[0] ? $signed({1'b0, weight[47:24]}) : $signed({1'b0, weight[23:0]});
  assign prod_next = mul_a * mul_b;
  assign prod_ext = {{23{prod[40]}}, prod};

  assign tr_s = {rm_s, dv_s[63]};
  assign tr_t = {rm_t, dv_t[63]};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= '{speed: cj.speed, turn: cj.turn, tstamp: cj.time_a};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      oldest    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_avail) begin
            cj    <= job;
            res_s <= '0;
            res_t <= '0;
            res_status <= ST_OK;
            unique case (job.cmd)
              CMD_CLEAR: begin
                count  <= '0;
                oldest <= '0;
                state  <= S_DONE;
              end
              CMD_APPEND: state <= S_CHECK;
              CMD_QUERY: begin
                if (job.reversed) begin
                  res_status <= ST_REVERSED;
                  state <= S_DONE;
                end else if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state <= S_DONE;
                end else state <= S_CHECK;
              end
              default: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state <= S_DONE;
                end else state <= S_CHECK;
              end
            endcase
          end
        end
        S_CHECK: begin
          mstep <= '0;
          state <= S_DONE;
          case (cj.cmd)
            CMD_APPEND: begin
              if (count != '0 && rd_data.tstamp > cj.time_a) res_status <= ST_OLDER;
              else if (cj.future) res_status <= ST_FUTURE;
              else if (count == CNT_W'(HISTORY_DEPTH)) res_status <= ST_FULL;
              else count <= count + CNT_W'(1);
            end
            CMD_QUERY: begin
              if (cj.time_a < rd_data.tstamp) res_status <= ST_BEFORE;
              else if (cj.too_short) res_status <= ST_SHORT;
              else begin
                cur_s <= rd_data.speed;
                cur_t <= rd_data.turn;
                start <= cj.time_a;
                j     <= CNT_W'(1);
                acc_s <= '0;
                acc_t <= '0;
                if (count > CNT_W'(1)) state <= S_ISSUE;
                else begin
                  weight    <= cj.window;
                  final_seg <= 1'b1;
                  state     <= S_MAC;
                end
              end
            end
            CMD_DELETE: begin
              if (cj.time_a < rd_data.tstamp) res_status <= ST_BEFORE;
              else begin
                kreg <= '0;
                j    <= CNT_W'(1);
                if (count > CNT_W'(1)) state <= S_ISSUE;
              end
            end
            default: ;
          endcase
        end
        S_ISSUE: state <= S_WALK;
        S_WALK: begin
          mstep <= '0;
          if (cj.cmd == CMD_DELETE) begin
            if (cj.time_a > rd_data.tstamp && !last_entry) begin
              kreg  <= j;
              j     <= j + CNT_W'(1);
              state <= S_ISSUE;
            end else begin
              if (del_k != '0) begin
                oldest <= oldest + del_drop[PTR_W-1:0];
                count  <= count - del_drop;
              end
              state <= S_DONE;
            end
          end else if (rd_data.tstamp >= cj.time_b) begin
            weight    <= cj.time_b - start;
            final_seg <= 1'b1;
            state     <= S_MAC;
          end else if (cj.time_a > rd_data.tstamp) begin
            // entry still before the window: it becomes the command in force
            cur_s <= rd_data.speed;
            cur_t <= rd_data.turn;
            if (last_entry) begin
              weight    <= cj.time_b - start;
              final_seg <= 1'b1;
              state     <= S_MAC;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_ISSUE;
            end
          end else begin
            weight    <= rd_data.tstamp - start;
            start     <= rd_data.tstamp;
            nxt_s     <= rd_data.speed;
            nxt_t     <= rd_data.turn;
            final_seg <= 1'b0;
            state     <= S_MAC;
          end
        end
        S_MAC: begin
          mstep <= mstep + 3'd1;
          prod  <= prod_next;
          case (mstep)
            3'd1: acc_s <= acc_s + prod_ext;
            3'd2: acc_s <= acc_s + (prod_ext <<< 24);
            3'd3: acc_t <= acc_t + prod_ext;
            3'd4: acc_t <= acc_t + (prod_ext <<< 24);
            default: ;
          endcase
          if (mstep == 3'd4) begin
            mstep <= '0;
            if (final_seg) begin
              neg_s <= acc_s[63];
              neg_t <= acc_t[63] ^ (prod_ext[63] && !acc_t[63] ? 1'b0 : 1'b0);
              state <= S_DIV;
            end else begin
              cur_s <= nxt_s;
              cur_t <= nxt_t;
              if (last_entry) begin
                weight    <= cj.time_b - start;
                final_seg <= 1'b1;
              end else begin
                j     <= j + CNT_W'(1);
                state <= S_ISSUE;
              end
            end
          end
          dcnt <= '0;
        end
        S_DIV: begin
          if (dcnt == 6'd0 && mstep == '0) begin
            // load magnitudes; turn sum is final only now
            neg_t <= acc_t[63];
            dv_s  <= acc_s[63] ? 64'(-acc_s) : 64'(acc_s);
            dv_t  <= acc_t[63] ? 64'(-acc_t) : 64'(acc_t);
            rm_s  <= '0;
            rm_t  <= '0;
            mstep <= 3'd1;
          end else begin
            if (tr_s >= {1'b0, cj.window}) begin
              rm_s <= TIME_W'(tr_s - {1'b0, cj.window});
              dv_s <= {dv_s[62:0], 1'b1};
            end else begin
              rm_s <= tr_s[TIME_W-1:0];
              dv_s <= {dv_s[62:0], 1'b0};
            end
            if (tr_t >= {1'b0, cj.window}) begin
              rm_t <= TIME_W'(tr_t - {1'b0, cj.window});
              dv_t <= {dv_t[62:0], 1'b1};
            end else begin
              rm_t <= tr_t[TIME_W-1:0];
              dv_t <= {dv_t[62:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
            if (dcnt == 6'd63) state <= S_SIGN;
          end
        end
        S_SIGN: begin
          mstep <= '0;
          res_s <= neg_s ? -$signed(dv_s[CMDV_W-1:0]) : $signed(dv_s[CMDV_W-1:0]);
          res_t <= neg_t ? -$signed(dv_t[CMDV_W-1:0]) : $signed(dv_t[CMDV_W-1:0]);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp_data  <= '{status: res_status, avg_speed: res_s, avg_turn: res_t,
                           entry_count: count};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCHA_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(HISTORY_DEPTH), "count above depth")
  `TCHA_ASSERT_IMPL(a_write_room, wr_en, count < CNT_W'(HISTORY_DEPTH), "write into full ring")
  `TCHA_ASSERT_NEXT(a_pop_busy, pop, state != S_IDLE, "popped item not taken up")
  `TCHA_ASSERT_NEXT(a_done_load, state == S_DONE && (!rsp_valid || !rsp_stall), rsp_valid,
    "finished result not presented")
endmodule

FILE: rtl/core/timed_command_history_average_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// cmd       in   cmd_valid/cmd_stall    tcha_pkg::in_beat_t
// rsp       out  rsp_valid/rsp_stall    tcha_pkg::out_beat_t
// cfg       in   wr_en                  wr_data (min window, us)
// Append and items rejected at the ring check pass through S_CHECK; clear, reversed
// or empty go straight to S_DONE. Delete walks the ring entry by entry via S_ISSUE/S_WALK.
// Query reads entries one at a time from the ring, runs each segment on the
// shared 16x24 multiplier in S_MAC, then the bit-serial dual divider in S_DIV.
// Reset is synchronous; ring contents are not cleared, only pointers.
// A two-beat queue splits intake from execution; a result held by rsp_stall
// blocks the next finish, and blocks intake only once the queue is full.
module timed_command_history_average_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  tcha_pkg::in_beat_t         cmd_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output tcha_pkg::out_beat_t        rsp_data,
  input  logic                       wr_en,
  input  logic [tcha_pkg::WIN_W-1:0] wr_data
);
  import tcha_pkg::*;

  logic [WIN_W-1:0] min_window;
  logic             q_full;
  logic             push;
  logic             pop;
  logic             avail;
  job_t             job_in;
  job_t             job_out;

  always_ff @(posedge clk) begin
    if (rst) min_window <= MIN_WINDOW_RESET;
    else if (wr_en) min_window <= wr_data;
  end

  tcha_front u_front (
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
    .min_window(min_window), .q_full(q_full), .push(push), .job(job_in)
  );

  tcha_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .job_in(job_in), .full(q_full),
    .pop(pop), .avail(avail), .job_out(job_out)
  );

  tcha_back u_back (
    .clk(clk), .rst(rst), .job_avail(avail), .job(job_out), .pop(pop),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );
endmodule
